@@ sv/frm_pkg.sv @@
`timescale 1ns / 1ps
package frm_pkg;

  localparam int WINDOW_DEF = 64;
  localparam int RATE_SCALE = 256000;
  localparam int SLEEP_NUM = 1000;
  localparam int SLEEP_W = 10;
  localparam int SLEEP_CLAMP = 300;
  localparam int FPS_W = 24;
  localparam int FPS_ZERO = 999 * 256;
  localparam int STAMP_W = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CALC_MODE = 3'd0,
    REG_FG_MAX    = 3'd1,
    REG_BG_MAX    = 3'd2,
    REG_FG_RATE   = 3'd3,
    REG_BG_RATE   = 3'd4,
    REG_FG_REV    = 3'd5,
    REG_BG_REV    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic accept;
    logic rd_prev;
    logic rd_first;
    logic wr;
    logic div_fps;
    logic div_slp;
    logic save_fps;
    logic latch_lim;
    logic save_slp;
    logic render_step;
    logic load_out;
  } frm_cmd_t;

  typedef struct packed {
    logic is_render;
    logic mwait;
    logic cap_zero;
    logic div_done;
    logic out_free;
  } frm_status_t;

endpackage

@@ sv/frm_ctrl.sv @@
`timescale 1ns / 1ps
module frm_ctrl import frm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        cfg_ready,
  input  frm_status_t status,
  output frm_cmd_t    cmd
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_RD_PREV  = 11'b00000000010,
    S_RD_FIRST = 11'b00000000100,
    S_WR       = 11'b00000001000,
    S_FPS_LOAD = 11'b00000010000,
    S_FPS_DIV  = 11'b00000100000,
    S_LIMIT    = 11'b00001000000,
    S_SLP_DIV  = 11'b00010000000,
    S_SLP_SAVE = 11'b00100000000,
    S_RENDER   = 11'b01000000000,
    S_FIN      = 11'b10000000000
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_RD_PREV;
        end
      end
      S_RD_PREV: begin
        if (status.is_render) begin
          state_next = S_RENDER;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next = S_RD_FIRST;
        end
      end
      S_RD_FIRST: begin
        cmd.rd_first = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr = 1'b1;
        state_next = S_FPS_LOAD;
      end
      S_FPS_LOAD: begin
        cmd.div_fps = 1'b1;
        state_next = S_FPS_DIV;
      end
      S_FPS_DIV: begin
        if (status.div_done) begin
          cmd.save_fps = 1'b1;
          state_next = status.mwait ? S_FIN : S_LIMIT;
        end
      end
      S_LIMIT: begin
        cmd.latch_lim = 1'b1;
        if (status.cap_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.div_slp = 1'b1;
          state_next = S_SLP_DIV;
        end
      end
      S_SLP_DIV: begin
        if (status.div_done) begin
          state_next = S_SLP_SAVE;
        end
      end
      S_SLP_SAVE: begin
        cmd.save_slp = 1'b1;
        state_next = S_FIN;
      end
      S_RENDER: begin
        cmd.render_step = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/frm_dp.sv @@
`timescale 1ns / 1ps
module frm_dp import frm_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  frm_cmd_t              cmd,
  output frm_status_t           status,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  command,
  input  logic [STAMP_W-1:0]    timestamp_ms,
  input  logic                  in_foreground,
  input  logic                  mouse_wait,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [FPS_W-1:0]      fps_q8,
  output logic [15:0]           frame_time_ms,
  output logic [SLEEP_W-1:0]    sleep_ms,
  output logic                  sleep_valid,
  output logic [7:0]            current_max,
  output logic                  foreground_now,
  output logic                  render_enable
);

  localparam int RING_LEN = WINDOW + 1;
  localparam int SLOT_W = $clog2(RING_LEN);
  localparam int NUM_W = $clog2(WINDOW * RATE_SCALE + 1);
  localparam int CNT_W = $clog2(NUM_W + 1);

  // configuration
  logic       calc_mode;
  logic [7:0] fg_max, bg_max, fg_rate, bg_rate;
  logic       fg_rev, bg_rev;
  logic       cfg_we;
  assign cfg_we = cfg_valid && cfg_ready;

  // captured request
  logic               req_render, req_fg, req_mwait;
  logic [STAMP_W-1:0] now;

  // ring
  logic [STAMP_W-1:0] ring [RING_LEN];
  logic [STAMP_W-1:0] rdata;
  logic [SLOT_W-1:0]  slot, prev_addr, first_addr, raddr;
  logic               full, first_pulse;

  // limiter state
  logic [SLEEP_W-1:0] prev_sleep;
  logic               focus;
  logic [7:0]         cap, period, skip_count;
  logic               reverse;

  // results
  logic [FPS_W-1:0]   res_fps;
  logic [15:0]        res_ftime;
  logic [SLEEP_W-1:0] res_sleep;
  logic               res_valid, res_render;
  logic [STAMP_W-1:0] elapsed;

  // divider
  logic [NUM_W-1:0]   div_num, div_rem, div_q;
  logic [STAMP_W-1:0] div_den;
  logic [CNT_W-1:0]   div_cnt;
  logic [NUM_W:0]     trial;
  logic               fits;

  logic [STAMP_W-1:0] diff;
  logic [7:0]         cap_sel, skip_inc;
  logic [SLOT_W-1:0]  frames;
  logic [NUM_W-1:0]   fps_num;
  logic [31:0]        q_wide;
  logic signed [17:0] slp_raw;

  function automatic logic [SLEEP_W-1:0] res_sleep_calc(
    input logic signed [17:0] raw,
    input logic               mode,
    input logic [SLEEP_W-1:0] base
  );
    logic [SLEEP_W-1:0] r;
    if (!mode) begin
      r = base;
    end else if (raw < 0) begin
      r = '0;
    end else if (raw > 18'sd300) begin
      r = SLEEP_W'(SLEEP_CLAMP);
    end else begin
      r = raw[SLEEP_W-1:0];
    end
    return r;
  endfunction

  assign first_pulse = !full && (slot == '0);
  assign prev_addr   = (slot == '0) ? SLOT_W'(WINDOW) : slot - SLOT_W'(1);
  assign first_addr  = !full ? '0 :
                       (slot == SLOT_W'(WINDOW)) ? '0 : slot + SLOT_W'(1);
  assign raddr       = cmd.rd_prev ? prev_addr : first_addr;
  assign diff        = now - rdata;
  // slot has already advanced past the stored stamp here
  assign frames      = full ? SLOT_W'(WINDOW) : slot - SLOT_W'(1);
  assign fps_num     = NUM_W'(frames) * NUM_W'(RATE_SCALE);
  assign cap_sel     = req_fg ? fg_max : bg_max;
  assign q_wide      = 32'(div_q);
  assign skip_inc    = (skip_count == 8'hFF) ? skip_count : skip_count + 8'd1;

  assign trial = {div_rem, div_num[NUM_W-1]};
  assign fits  = (div_den[STAMP_W-1:NUM_W+1] == '0) && (trial >= div_den[NUM_W:0]);

  assign slp_raw = $signed({8'b0, div_q[SLEEP_W-1:0]}) - $signed({2'b0, res_ftime})
                 + $signed({8'b0, prev_sleep});

  assign status.is_render = req_render;
  assign status.mwait     = req_mwait;
  assign status.cap_zero  = (cap_sel == 8'd0);
  assign status.div_done  = (div_cnt == '0);
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.rd_prev || cmd.rd_first) begin
      rdata <= ring[raddr];
    end
    if (cmd.wr) begin
      ring[slot] <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calc_mode  <= 1'b1;
      fg_max     <= 8'd50;
      bg_max     <= 8'd30;
      fg_rate    <= 8'd1;
      bg_rate    <= 8'd30;
      fg_rev     <= 1'b0;
      bg_rev     <= 1'b0;
      slot       <= '0;
      full       <= 1'b0;
      prev_sleep <= '0;
      focus      <= 1'b0;
      cap        <= 8'd0;
      period     <= 8'd1;
      reverse    <= 1'b0;
      skip_count <= 8'd0;
      div_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_CALC_MODE: begin
            calc_mode <= cfg_data[0];
            // restart the window
            slot <= '0;
            full <= 1'b0;
          end
          REG_FG_MAX:  fg_max  <= cfg_data;
          REG_BG_MAX:  bg_max  <= cfg_data;
          REG_FG_RATE: fg_rate <= cfg_data;
          REG_BG_RATE: bg_rate <= cfg_data;
          REG_FG_REV:  fg_rev  <= cfg_data[0];
          REG_BG_REV:  bg_rev  <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.wr) begin
        if (slot == SLOT_W'(WINDOW)) begin
          slot <= '0;
          full <= 1'b1;
        end else begin
          slot <= slot + SLOT_W'(1);
        end
      end
      if (cmd.div_fps) begin
        div_cnt <= CNT_W'(NUM_W);
      end else if (cmd.div_slp) begin
        div_cnt <= CNT_W'(SLEEP_W);
      end else if (div_cnt != '0) begin
        div_cnt <= div_cnt - CNT_W'(1);
      end
      if (cmd.latch_lim) begin
        focus   <= req_fg;
        cap     <= cap_sel;
        period  <= req_fg ? fg_rate : bg_rate;
        reverse <= req_fg ? fg_rev : bg_rev;
      end
      if (cmd.save_slp) begin
        prev_sleep <= res_sleep_calc(slp_raw, calc_mode, div_q[SLEEP_W-1:0]);
      end
      if (cmd.render_step) begin
        if (period != 8'd0 && skip_inc >= period) begin
          skip_count <= 8'd0;
        end else begin
          skip_count <= skip_inc;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_render <= command;
      now        <= timestamp_ms;
      req_fg     <= in_foreground;
      req_mwait  <= mouse_wait;
      res_fps    <= '0;
      res_ftime  <= '0;
      res_sleep  <= '0;
      res_valid  <= 1'b0;
      res_render <= 1'b0;
    end
    if (cmd.rd_first) begin
      res_ftime <= first_pulse ? 16'd0 :
                   (diff[STAMP_W-1:16] != '0) ? 16'hFFFF : diff[15:0];
    end
    if (cmd.wr) begin
      elapsed <= first_pulse ? '0 : diff;
    end
    if (cmd.div_fps) begin
      div_num <= fps_num;
      div_den <= elapsed;
      div_rem <= '0;
      div_q   <= '0;
    end else if (cmd.div_slp) begin
      div_num <= NUM_W'(SLEEP_NUM) << (NUM_W - SLEEP_W);
      div_den <= STAMP_W'(cap_sel);
      div_rem <= '0;
      div_q   <= '0;
    end else if (div_cnt != '0) begin
      div_num <= div_num << 1;
      div_rem <= fits ? NUM_W'(trial - div_den[NUM_W:0]) : trial[NUM_W-1:0];
      div_q   <= {div_q[NUM_W-2:0], fits};
    end
    if (cmd.save_fps) begin
      if (elapsed == '0) begin
        res_fps <= FPS_W'(FPS_ZERO);
      end else if (q_wide > 32'hFFFFFF) begin
        res_fps <= '1;
      end else begin
        res_fps <= q_wide[FPS_W-1:0];
      end
    end
    if (cmd.latch_lim) begin
      res_valid <= 1'b1;
    end
    if (cmd.save_slp) begin
      res_sleep <= res_sleep_calc(slp_raw, calc_mode, div_q[SLEEP_W-1:0]);
    end
    if (cmd.render_step) begin
      if (period != 8'd0 && skip_inc >= period) begin
        res_render <= !reverse;
      end else begin
        res_render <= reverse;
      end
    end
    if (cmd.load_out) begin
      fps_q8         <= res_fps;
      frame_time_ms  <= res_ftime;
      sleep_ms       <= res_sleep;
      sleep_valid    <= res_valid;
      current_max    <= cap;
      foreground_now <= focus;
      render_enable  <= res_render;
    end
  end

endmodule

@@ sv/frame_rate_meter_and_pacer.sv @@
`timescale 1ns / 1ps
// A render request passes S_RD_PREV and S_RENDER, which registers the render decision.
// A frame pulse runs the rate division over W = clog2(WINDOW*256000+1) bits (W = 24
// at WINDOW 64) and the sleep division, both on the shared one-bit-per-cycle divider.
// Throughput: one request at a time; the next is taken once the output registers load.
// Reset (rst, synchronous) restores register defaults and empties the timestamp window.
module frame_rate_meter_and_pacer import frm_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  command,
  input  logic [STAMP_W-1:0]    timestamp_ms,
  input  logic                  in_foreground,
  input  logic                  mouse_wait,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FPS_W-1:0]      fps_q8,
  output logic [15:0]           frame_time_ms,
  output logic [SLEEP_W-1:0]    sleep_ms,
  output logic                  sleep_valid,
  output logic [7:0]            current_max,
  output logic                  foreground_now,
  output logic                  render_enable,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  frm_cmd_t    cmd;
  frm_status_t status;

  frm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  frm_dp #(.WINDOW(WINDOW)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .command        (command),
    .timestamp_ms   (timestamp_ms),
    .in_foreground  (in_foreground),
    .mouse_wait     (mouse_wait),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .fps_q8         (fps_q8),
    .frame_time_ms  (frame_time_ms),
    .sleep_ms       (sleep_ms),
    .sleep_valid    (sleep_valid),
    .current_max    (current_max),
    .foreground_now (foreground_now),
    .render_enable  (render_enable)
  );

endmodule
